// ===== rtl/ptl_pkg.sv =====
// ----------------------------------------------------------------------------
// Pedestrian traffic light package
// Shared types, register indexes, lamp masks and small helper functions.
// ----------------------------------------------------------------------------
package ptl_pkg;

  // Tick counter width and the number of steps the remainder unit takes.
  localparam int TICK_W    = 16;
  localparam int REM_STEPS = TICK_W;
  localparam int STEP_W    = $clog2(REM_STEPS + 1);
  localparam int LAMP_W    = 6;

  typedef logic [LAMP_W-1:0] lamp_t;

  // Lamp masks: car green, yellow, red, then pedestrian green, yellow, red.
  localparam lamp_t LAMP_CG = 6'b000001;
  localparam lamp_t LAMP_CY = 6'b000010;
  localparam lamp_t LAMP_CR = 6'b000100;
  localparam lamp_t LAMP_PG = 6'b001000;
  localparam lamp_t LAMP_PY = 6'b010000;
  localparam lamp_t LAMP_PR = 6'b100000;

  typedef enum logic [2:0] {
    PH_GREEN    = 3'd0,
    PH_YELLOW   = 3'd1,
    PH_RED      = 3'd2,
    PH_REDYEL   = 3'd3,
    PH_DEBOUNCE = 3'd4,
    PH_PED      = 3'd5
  } phase_t;

  // Steps of a pedestrian sequence: lead blink, walk, tail blink.
  typedef enum logic [1:0] {
    PED_LEAD = 2'd0,
    PED_WALK = 2'd1,
    PED_TAIL = 2'd2
  } ped_step_t;

  // Blink segments: yellow on, yellow off, yellow on again.
  localparam logic [1:0] SEG_ON_A = 2'd0;
  localparam logic [1:0] SEG_OFF  = 2'd1;
  localparam logic [1:0] SEG_ON_B = 2'd2;

  typedef enum logic [2:0] {
    REG_MAIN_PHASE   = 3'd0,
    REG_CHECK        = 3'd1,
    REG_BLINK_ON     = 3'd2,
    REG_BLINK_OFF    = 3'd3,
    REG_BLINK_ROUNDS = 3'd4,
    REG_WALK         = 3'd5,
    REG_DEBOUNCE     = 3'd6
  } cfg_reg_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] main_phase_ticks;
    logic [7:0]  check_ticks;
    logic [7:0]  blink_on_ticks;
    logic [7:0]  blink_off_ticks;
    logic [3:0]  blink_rounds;
    logic [15:0] walk_ticks;
    logic [7:0]  debounce_ticks;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    lamp_t  lamps;
    phase_t phase;
  } result_t;

  // Realigned check remainder handed from the remainder unit to the FSM.
  typedef struct packed {
    logic       load;
    logic [7:0] value;
  } rem_load_t;

  // A zero duration or count behaves as one.
  function automatic logic [7:0] nz8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [15:0] nz16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [3:0] nz4(input logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

  function automatic lamp_t lamp_upd(input lamp_t l, input lamp_t set_m, input lamp_t clr_m);
    return (l & ~clr_m) | set_m;
  endfunction

endpackage

// ===== rtl/pedestrian_traffic_light_fsm_top.sv =====
// ----------------------------------------------------------------------------
// Pedestrian traffic light controller
// Tick and press beats in, lamp and phase beats out, with a register port.
//
//   channel  handshake                  payload
//   input    in_valid / in_ready        req_type, button_level
//   output   out_valid / out_ready      six lamps, phase_code
//   config   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One input beat is accepted per cycle while the buffer has room and no
// remainder pass runs; its result goes into a two-entry result buffer, so
// input keeps flowing while one result waits. A check interval write starts
// a remainder pass to realign the press-check phase, in_ready and cfg_ready low.
// Reset restores the register defaults and the car green phase.
// ----------------------------------------------------------------------------
module pedestrian_traffic_light_fsm_top
  import ptl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic        button_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        car_green,
  output logic        car_yellow,
  output logic        car_red,
  output logic        ped_green,
  output logic        ped_yellow,
  output logic        ped_red,
  output logic [2:0]  phase_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t              cfg;
  logic              in_fire;
  logic              out_fire;
  logic              cfg_fire;
  logic              rem_busy;
  rem_load_t         rem_load;
  logic [TICK_W-1:0] tick_count;
  result_t           fsm_result;
  result_t           slot0;
  result_t           slot1;
  logic [1:0]        q_count;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (q_count != 2'd2) && !rem_busy;
  assign cfg_ready = !rem_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.main_phase_ticks <= 16'd500;
      cfg.check_ticks      <= 8'd10;
      cfg.blink_on_ticks   <= 8'd39;
      cfg.blink_off_ticks  <= 8'd19;
      cfg.blink_rounds     <= 4'd5;
      cfg.walk_ticks       <= 16'd500;
      cfg.debounce_ticks   <= 8'd50;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAIN_PHASE:   cfg.main_phase_ticks <= cfg_data;
        REG_CHECK:        cfg.check_ticks      <= cfg_data[7:0];
        REG_BLINK_ON:     cfg.blink_on_ticks   <= cfg_data[7:0];
        REG_BLINK_OFF:    cfg.blink_off_ticks  <= cfg_data[7:0];
        REG_BLINK_ROUNDS: cfg.blink_rounds     <= cfg_data[3:0];
        REG_WALK:         cfg.walk_ticks       <= cfg_data;
        REG_DEBOUNCE:     cfg.debounce_ticks   <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  ptl_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_fire && (cfg_reg_t'(cfg_index) == REG_CHECK)),
    .divisor  (cfg_data[7:0]),
    .dividend (tick_count),
    .busy     (rem_busy),
    .result   (rem_load)
  );

  ptl_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_fire    (in_fire),
    .req_type     (req_type),
    .button_level (button_level),
    .rem_load     (rem_load),
    .tick_count   (tick_count),
    .result       (fsm_result)
  );

  // Two-entry result buffer; slot0 is the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      case ({in_fire, out_fire})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (q_count == 2'd2) begin
        slot0 <= slot1;
        if (in_fire) begin
          slot1 <= fsm_result;
        end
      end else if (in_fire) begin
        slot0 <= fsm_result;
      end
    end else if (in_fire) begin
      if (q_count == 2'd0) begin
        slot0 <= fsm_result;
      end else begin
        slot1 <= fsm_result;
      end
    end
  end

  assign out_valid  = (q_count != 2'd0);
  assign car_green  = slot0.lamps[0];
  assign car_yellow = slot0.lamps[1];
  assign car_red    = slot0.lamps[2];
  assign ped_green  = slot0.lamps[3];
  assign ped_yellow = slot0.lamps[4];
  assign ped_red    = slot0.lamps[5];
  assign phase_code = slot0.phase;

  // Nothing is accepted while the check phase is being realigned.
  a_hold_while_busy: assert property (@(posedge clk) disable iff (rst)
    rem_busy |-> (!in_ready && !cfg_ready))
    else $error("beat accepted during remainder pass");

  // The buffer never overfills.
  a_buffer_bound: assert property (@(posedge clk) disable iff (rst)
    q_count != 2'd3)
    else $error("result buffer overflow");

  // Every accepted beat leaves a result to show.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

// ===== rtl/ptl_rem.sv =====
// ----------------------------------------------------------------------------
// Check remainder unit
// Restoring remainder of the tick count by a new check interval, one bit a
// cycle, used to realign the press-check phase after the interval changes.
// ----------------------------------------------------------------------------
module ptl_rem
  import ptl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [7:0]        divisor,
  input  logic [TICK_W-1:0] dividend,
  output logic              busy,
  output rem_load_t         result
);

  logic [STEP_W-1:0] steps;
  logic [TICK_W-1:0] dividend_sh;
  logic [7:0]        divisor_r;
  logic [7:0]        remainder;
  logic [8:0]        trial;
  logic [8:0]        diff;
  logic [7:0]        rem_step;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  assign trial    = {remainder, dividend_sh[TICK_W-1]};
  assign diff     = trial - {1'b0, divisor_r};
  assign rem_step = (trial >= {1'b0, divisor_r}) ? diff[7:0] : trial[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(REM_STEPS);
    end else if (steps != '0) begin
      steps <= steps - STEP_W'(1);
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      dividend_sh <= dividend;
      divisor_r   <= nz8(divisor);
      remainder   <= '0;
    end else if (steps != '0) begin
      dividend_sh <= {dividend_sh[TICK_W-2:0], 1'b0};
      remainder   <= rem_step;
    end
  end

  // The final step's value goes straight to the FSM.
  assign busy         = (steps != '0);
  assign result.load  = (steps == STEP_W'(1));
  assign result.value = rem_step;

endmodule

// ===== rtl/ptl_fsm.sv =====
// ----------------------------------------------------------------------------
// Traffic light sequencer
// Phase state machine: blink segments, press checks, debounce and the
// pedestrian sequences. One tick or press beat is handled per update.
// ----------------------------------------------------------------------------
module ptl_fsm
  import ptl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              item_fire,
  input  logic              req_type,
  input  logic              button_level,
  input  rem_load_t         rem_load,
  output logic [TICK_W-1:0] tick_count,
  output result_t           result
);

  typedef struct packed {
    phase_t            phase;
    ped_step_t         ped_step;
    phase_t            saved_phase;
    logic [TICK_W-1:0] tick_count;
    logic [3:0]        round_count;
    logic [1:0]        segment;
    logic              press_pending;
    lamp_t             lamp_bits;
    logic [7:0]        check_rem;
  } fsm_state_t;

  typedef struct packed {
    logic [1:0] segment;
    logic [3:0] round_count;
    lamp_t      lamp_bits;
    logic       done;
  } blink_t;

  // Advance one blink segment; done is set when the last round ends.
  function automatic blink_t blink_step(input logic [1:0] seg, input logic [3:0] rnd,
                                        input lamp_t l, input logic [3:0] rounds,
                                        input lamp_t y_on, input lamp_t y_off);
    blink_t b;
    b.segment     = seg;
    b.round_count = rnd;
    b.lamp_bits   = l;
    b.done        = 1'b0;
    case (seg)
      SEG_ON_A: begin
        b.segment   = SEG_OFF;
        b.lamp_bits = lamp_upd(l, '0, y_off);
      end
      SEG_OFF: begin
        b.segment   = SEG_ON_B;
        b.lamp_bits = lamp_upd(l, y_on, '0);
      end
      default: begin
        b.round_count = rnd + 4'd1;
        if (b.round_count >= nz4(rounds)) begin
          b.done = 1'b1;
        end else begin
          b.segment   = SEG_ON_A;
          b.lamp_bits = lamp_upd(l, y_on, '0);
        end
      end
    endcase
    return b;
  endfunction

  // A press found at a check: remember the phase and start the debounce wait.
  function automatic fsm_state_t f_check(input fsm_state_t s, input phase_t sp);
    fsm_state_t n;
    n               = s;
    n.press_pending = 1'b0;
    n.saved_phase   = sp;
    n.phase         = PH_DEBOUNCE;
    n.tick_count    = '0;
    n.check_rem     = '0;
    return n;
  endfunction

  function automatic fsm_state_t f_enter(input fsm_state_t s, input phase_t p);
    fsm_state_t n;
    n             = s;
    n.phase       = p;
    n.tick_count  = '0;
    n.check_rem   = '0;
    n.segment     = SEG_ON_A;
    n.round_count = '0;
    case (p)
      PH_GREEN: n.lamp_bits = lamp_upd(s.lamp_bits, LAMP_CG,
                                       LAMP_PG | LAMP_PY | LAMP_CY | LAMP_CR);
      PH_RED:   n.lamp_bits = lamp_upd(s.lamp_bits, LAMP_CR,
                                       LAMP_PY | LAMP_PR | LAMP_CG | LAMP_CY);
      default:  n.lamp_bits = lamp_upd(s.lamp_bits, LAMP_CY, '0);
    endcase
    return n;
  endfunction

  function automatic fsm_state_t f_walk(input fsm_state_t s);
    fsm_state_t n;
    n            = s;
    n.phase      = PH_PED;
    n.ped_step   = PED_WALK;
    n.tick_count = '0;
    n.check_rem  = '0;
    n.lamp_bits  = lamp_upd(s.lamp_bits, LAMP_PG | LAMP_CR,
                            LAMP_PR | LAMP_CG | LAMP_PY | LAMP_CY);
    return n;
  endfunction

  function automatic fsm_state_t f_blink(input fsm_state_t s, input ped_step_t stp);
    fsm_state_t n;
    n             = s;
    n.phase       = PH_PED;
    n.ped_step    = stp;
    n.tick_count  = '0;
    n.check_rem   = '0;
    n.segment     = SEG_ON_A;
    n.round_count = '0;
    n.lamp_bits   = lamp_upd(s.lamp_bits, LAMP_CY | LAMP_PY, '0);
    return n;
  endfunction

  fsm_state_t        st;
  fsm_state_t        st_next;
  fsm_state_t        seg_done;
  logic [TICK_W-1:0] tick_inc;
  logic [7:0]        rem_inc;
  logic [7:0]        check_len;
  logic [7:0]        seg_len;
  logic              seg_end;
  blink_t            blink_car;
  blink_t            blink_ped;
  phase_t            main_ph;

  // Shared per-tick arithmetic.
  assign tick_inc  = st.tick_count + TICK_W'(1);
  assign check_len = nz8(cfg.check_ticks);
  assign rem_inc   = ((st.check_rem + 8'd1) == check_len) ? 8'd0 : st.check_rem + 8'd1;
  assign seg_len   = nz8((st.segment == SEG_OFF) ? cfg.blink_off_ticks : cfg.blink_on_ticks);
  assign seg_end   = (tick_inc >= {8'd0, seg_len});
  assign main_ph   = (st.phase == PH_RED) ? PH_RED : PH_GREEN;

  assign blink_car = blink_step(st.segment, st.round_count, st.lamp_bits, cfg.blink_rounds,
                                LAMP_CY, LAMP_CY | LAMP_PY);
  assign blink_ped = blink_step(st.segment, st.round_count, st.lamp_bits, cfg.blink_rounds,
                                LAMP_CY | LAMP_PY, LAMP_CY | LAMP_PY);

  // State after a blink segment ends, before any check or phase change.
  always_comb begin
    seg_done            = st;
    seg_done.tick_count = '0;
    seg_done.check_rem  = '0;
    if (st.phase == PH_PED) begin
      seg_done.segment     = blink_ped.segment;
      seg_done.round_count = blink_ped.round_count;
      seg_done.lamp_bits   = blink_ped.lamp_bits;
    end else begin
      seg_done.segment     = blink_car.segment;
      seg_done.round_count = blink_car.round_count;
      seg_done.lamp_bits   = blink_car.lamp_bits;
    end
  end

  // Next state for one accepted beat.
  always_comb begin
    st_next = st;
    if (item_fire && req_type) begin
      if (st.phase != PH_PED) begin
        st_next.press_pending = 1'b1;
      end
    end else if (item_fire) begin
      st_next.tick_count = tick_inc;
      st_next.check_rem  = rem_inc;
      case (st.phase)
        PH_YELLOW, PH_REDYEL: begin
          if (seg_end) begin
            if (blink_car.done && !st.press_pending) begin
              st_next = f_enter(seg_done, (st.phase == PH_YELLOW) ? PH_RED : PH_GREEN);
            end else if (st.press_pending) begin
              st_next = f_check(seg_done, st.phase);
            end else begin
              st_next = seg_done;
            end
          end
        end
        PH_DEBOUNCE: begin
          if (tick_inc >= {8'd0, nz8(cfg.debounce_ticks)}) begin
            if (button_level) begin
              if (st.press_pending) begin
                st_next = f_check(st, st.saved_phase);
              end else begin
                st_next = f_enter(st, PH_GREEN);
              end
            end else begin
              st_next.press_pending = 1'b0;
              case (st.saved_phase)
                PH_GREEN, PH_YELLOW: begin
                  st_next.lamp_bits = lamp_upd(st.lamp_bits, LAMP_PR | LAMP_CG,
                                               LAMP_PG | LAMP_PY | LAMP_CY | LAMP_CR);
                  st_next = f_blink(st_next, PED_LEAD);
                end
                PH_RED: st_next = f_walk(st_next);
                PH_REDYEL: begin
                  st_next.lamp_bits = lamp_upd(st.lamp_bits, LAMP_PG | LAMP_CR,
                                               LAMP_PR | LAMP_CG | LAMP_PY | LAMP_CY);
                  st_next = f_blink(st_next, PED_LEAD);
                end
                default: st_next = f_enter(st_next, PH_GREEN);
              endcase
            end
          end
        end
        PH_PED: begin
          if (st.ped_step == PED_WALK) begin
            if (tick_inc >= nz16(cfg.walk_ticks)) begin
              st_next = f_blink(st_next, PED_TAIL);
            end
          end else if (seg_end) begin
            if (!blink_ped.done) begin
              st_next = seg_done;
            end else if (st.ped_step == PED_LEAD) begin
              st_next = f_walk(seg_done);
            end else begin
              st_next = f_enter(seg_done, PH_GREEN);
            end
          end
        end
        default: begin
          // Car green and car red; any other code is treated as green.
          st_next.phase = main_ph;
          if (tick_inc >= nz16(cfg.main_phase_ticks)) begin
            if (st.press_pending) begin
              st_next = f_check(st_next, main_ph);
            end else begin
              st_next = f_enter(st_next, (main_ph == PH_GREEN) ? PH_YELLOW : PH_REDYEL);
            end
          end else if (rem_inc == 8'd0 && st.press_pending) begin
            st_next = f_check(st_next, main_ph);
          end
        end
      endcase
    end
    // The remainder unit realigns the check phase after a new interval.
    if (rem_load.load) begin
      st_next.check_rem = rem_load.value;
    end
  end

  // Result beat reflects the state after the update.
  always_comb begin
    result.lamps = st_next.lamp_bits;
    result.phase = st_next.phase;
  end

  assign tick_count = st.tick_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_GREEN;
      st.ped_step      <= PED_LEAD;
      st.saved_phase   <= PH_GREEN;
      st.tick_count    <= '0;
      st.round_count   <= '0;
      st.segment       <= SEG_ON_A;
      st.press_pending <= 1'b0;
      st.lamp_bits     <= LAMP_CG;
      st.check_rem     <= '0;
    end else begin
      st <= st_next;
    end
  end

  // A press is never left pending once a pedestrian sequence runs.
  a_no_press_in_ped: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_PED) |-> !st.press_pending)
    else $error("press latched during pedestrian sequence");

  // Debounce always remembers a car phase to return to.
  a_saved_car_phase: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_DEBOUNCE) |-> (st.saved_phase == PH_GREEN || st.saved_phase == PH_YELLOW
                                   || st.saved_phase == PH_RED || st.saved_phase == PH_REDYEL))
    else $error("debounce without a saved car phase");

  // The sequencer only ever holds a defined phase code.
  a_phase_defined: assert property (@(posedge clk) disable iff (rst)
    st.phase <= PH_PED)
    else $error("undefined phase code");

endmodule

// ===== bench/tb_pedestrian_traffic_light_fsm_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pedestrian traffic light controller testbench
// Sends tick and press beats through a queue-fed driver with random gaps,
// stalls the result channel at random, and checks each lamp and phase beat
// against a cycle-free model of the light sequence. Register settings are
// changed between traffic phases, from the smallest to the largest values.
// ----------------------------------------------------------------------------
module tb_pedestrian_traffic_light_fsm_top
  import ptl_pkg::*;
();

  localparam logic       REQ_TICK   = 1'b0;
  localparam logic       REQ_PRESS  = 1'b1;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         SETTLE_CYCLES = 24;

  typedef struct {
    logic req;
    logic level;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic        button_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        car_green;
  logic        car_yellow;
  logic        car_red;
  logic        ped_green;
  logic        ped_yellow;
  logic        ped_red;
  logic [2:0]  phase_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  pedestrian_traffic_light_fsm_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .button_level(button_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .car_green(car_green), .car_yellow(car_yellow), .car_red(car_red),
    .ped_green(ped_green), .ped_yellow(ped_yellow), .ped_red(ped_red),
    .phase_code(phase_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Pending stimulus and expected light beats.
  beat_t   beat_q[$];
  result_t light_q[$];
  int      queued_n = 0;
  int      accepted_n = 0;
  int      seen_n = 0;
  int      err_n = 0;
  int      cycle_n = 0;
  logic    in_taken = 1'b0;

  // Model state of the light sequence.
  phase_t      ph_m;
  ped_step_t   walk_step_m;
  logic [2:0]  saved_ph_m;
  logic [15:0] tick_m;
  logic [3:0]  round_m;
  logic [1:0]  seg_m;
  bit          press_m;
  lamp_t       lamps_m;

  // Model copy of the register file.
  logic [15:0] main_len;
  logic [7:0]  check_len;
  logic [7:0]  on_len;
  logic [7:0]  off_len;
  logic [3:0]  rounds_n;
  logic [15:0] walk_len;
  logic [7:0]  deb_len;

  // A zero length or count behaves as one.
  function automatic int floor1(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void set_lamps(input lamp_t on_m, input lamp_t off_m);
    lamps_m = (lamps_m & ~off_m) | on_m;
  endfunction

  // A latched press moves the light into the debounce wait.
  function automatic bit latch_check(input logic [2:0] from_ph);
    if (!press_m) return 1'b0;
    press_m = 1'b0;
    saved_ph_m = from_ph;
    ph_m = PH_DEBOUNCE;
    tick_m = 16'd0;
    return 1'b1;
  endfunction

  function automatic void start_phase(input phase_t p);
    ph_m = p;
    tick_m = 16'd0;
    seg_m = SEG_ON_A;
    round_m = 4'd0;
    if (p == PH_GREEN) set_lamps(LAMP_CG, LAMP_PG | LAMP_PY | LAMP_CY | LAMP_CR);
    else if (p == PH_RED) set_lamps(LAMP_CR, LAMP_PY | LAMP_PR | LAMP_CG | LAMP_CY);
    else set_lamps(LAMP_CY, '0);
  endfunction

  function automatic void start_walk();
    ph_m = PH_PED;
    walk_step_m = PED_WALK;
    tick_m = 16'd0;
    set_lamps(LAMP_PG | LAMP_CR, LAMP_PR | LAMP_CG | LAMP_PY | LAMP_CY);
  endfunction

  function automatic void start_dblink(input ped_step_t step);
    ph_m = PH_PED;
    walk_step_m = step;
    tick_m = 16'd0;
    seg_m = SEG_ON_A;
    round_m = 4'd0;
    set_lamps(LAMP_CY | LAMP_PY, '0);
  endfunction

  function automatic int segment_len();
    return floor1((seg_m == SEG_OFF) ? off_len : on_len);
  endfunction

  // Moves a blink to its next segment; true once all rounds are done.
  function automatic bit blink_next(input lamp_t on_m, input lamp_t off_m);
    tick_m = 16'd0;
    if (seg_m == SEG_ON_A) begin
      seg_m = SEG_OFF;
      set_lamps('0, off_m);
    end else if (seg_m == SEG_OFF) begin
      seg_m = SEG_ON_B;
      set_lamps(on_m, '0);
    end else begin
      round_m = round_m + 4'd1;
      if (round_m >= floor1(rounds_n)) return 1'b1;
      seg_m = SEG_ON_A;
      set_lamps(on_m, '0);
    end
    return 1'b0;
  endfunction

  // One tick of time passes.
  function automatic void tick_update(input logic level);
    tick_m = tick_m + 16'd1;
    case (ph_m)
      PH_YELLOW, PH_REDYEL: begin
        if (tick_m >= segment_len()) begin
          if (blink_next(LAMP_CY, LAMP_CY | LAMP_PY)) begin
            if (!latch_check(ph_m)) begin
              if (ph_m == PH_YELLOW) start_phase(PH_RED);
              else start_phase(PH_GREEN);
            end
          end else begin
            void'(latch_check(ph_m));
          end
        end
      end
      PH_DEBOUNCE: begin
        if (tick_m >= floor1(deb_len)) begin
          if (level) begin
            // Long press: back to green, or straight into another wait.
            if (!latch_check(saved_ph_m)) start_phase(PH_GREEN);
          end else begin
            press_m = 1'b0;
            case (saved_ph_m)
              PH_GREEN, PH_YELLOW: begin
                set_lamps(LAMP_PR | LAMP_CG, LAMP_PG | LAMP_PY | LAMP_CY | LAMP_CR);
                start_dblink(PED_LEAD);
              end
              PH_RED: start_walk();
              PH_REDYEL: begin
                set_lamps(LAMP_PG | LAMP_CR, LAMP_PR | LAMP_CG | LAMP_PY | LAMP_CY);
                start_dblink(PED_LEAD);
              end
              default: start_phase(PH_GREEN);
            endcase
          end
        end
      end
      PH_PED: begin
        if (walk_step_m == PED_WALK) begin
          if (tick_m >= floor1(walk_len)) start_dblink(PED_TAIL);
        end else if (tick_m >= segment_len()) begin
          if (blink_next(LAMP_CY | LAMP_PY, LAMP_CY | LAMP_PY)) begin
            if (walk_step_m == PED_LEAD) start_walk();
            else start_phase(PH_GREEN);
          end
        end
      end
      default: begin
        if (ph_m != PH_RED) ph_m = PH_GREEN;
        if (tick_m >= floor1(main_len)) begin
          if (!latch_check(ph_m)) begin
            if (ph_m == PH_GREEN) start_phase(PH_YELLOW);
            else start_phase(PH_REDYEL);
          end
        end else if (tick_m % floor1(check_len) == 0) begin
          void'(latch_check(ph_m));
        end
      end
    endcase
  endfunction

  // Applies one accepted beat and queues the lamps it should produce.
  function automatic void predict_lights(input logic req, input logic level);
    result_t r;
    if (req == REQ_PRESS) begin
      if (ph_m != PH_PED) press_m = 1'b1;
    end else begin
      tick_update(level);
    end
    r.lamps = lamps_m;
    r.phase = ph_m;
    light_q.push_back(r);
  endfunction

  function automatic void reset_model();
    main_len = 16'd500;
    check_len = 8'd10;
    on_len = 8'd39;
    off_len = 8'd19;
    rounds_n = 4'd5;
    walk_len = 16'd500;
    deb_len = 8'd50;
    ph_m = PH_GREEN;
    walk_step_m = PED_LEAD;
    saved_ph_m = PH_GREEN;
    tick_m = 16'd0;
    round_m = 4'd0;
    seg_m = SEG_ON_A;
    press_m = 1'b0;
    lamps_m = LAMP_CG;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      REG_MAIN_PHASE:   main_len = val;
      REG_CHECK:        check_len = val[7:0];
      REG_BLINK_ON:     on_len = val[7:0];
      REG_BLINK_OFF:    off_len = val[7:0];
      REG_BLINK_ROUNDS: rounds_n = val[3:0];
      REG_WALK:         walk_len = val;
      REG_DEBOUNCE:     deb_len = val[7:0];
      default: ;
    endcase
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_n++;
    end
  endtask

  task automatic push_beat(input logic req, input logic level);
    beat_t b;
    b.req = req;
    b.level = level;
    beat_q.push_back(b);
    queued_n++;
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      push_beat(($urandom_range(0, 99) < 12) ? REQ_PRESS : REQ_TICK,
                1'($urandom_range(0, 1)));
    end
  endtask

  // Waits until every beat is in and every light beat is out.
  task automatic drain();
    while (accepted_n != queued_n || seen_n != accepted_n) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] main_v, input logic [15:0] chk_v,
                              input logic [15:0] on_v, input logic [15:0] off_v,
                              input logic [15:0] rnd_v, input logic [15:0] walk_v,
                              input logic [15:0] deb_v);
    write_reg(REG_MAIN_PHASE, main_v);
    write_reg(REG_CHECK, chk_v);
    write_reg(REG_BLINK_ON, on_v);
    write_reg(REG_BLINK_OFF, off_v);
    write_reg(REG_BLINK_ROUNDS, rnd_v);
    write_reg(REG_WALK, walk_v);
    write_reg(REG_DEBOUNCE, deb_v);
  endtask

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Input driver: holds a beat until it is taken, then idles or sends the next.
  int gap_n = 0;
  bit calm_in = 1'b0;
  always @(negedge clk) begin
    beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Beat still waiting for acceptance.
    end else if (gap_n > 0) begin
      in_valid <= 1'b0;
      gap_n--;
    end else if (beat_q.size() > 0) begin
      nxt = beat_q.pop_front();
      in_valid <= 1'b1;
      req_type <= nxt.req;
      button_level <= nxt.level;
      gap_n = calm_in ? 0 : pick_gap();
      if ($urandom_range(0, 40) == 0) calm_in = !calm_in;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result stalls.
  int stall_n = 0;
  bit calm_out = 1'b0;
  always @(negedge clk) begin
    if (stall_n > 0) begin
      out_ready <= 1'b0;
      stall_n--;
    end else begin
      out_ready <= 1'b1;
      if (!calm_out && $urandom_range(0, 3) == 0) stall_n = pick_gap();
      if ($urandom_range(0, 40) == 0) calm_out = !calm_out;
    end
  end

  // Monitor: checks light beats, then predicts from accepted input beats.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_n++;
        if (light_q.size() == 0) begin
          $error("light beat arrived with no expectation waiting");
          err_n++;
        end else begin
          want = light_q.pop_front();
          check_field("car_green", want.lamps[0], car_green);
          check_field("car_yellow", want.lamps[1], car_yellow);
          check_field("car_red", want.lamps[2], car_red);
          check_field("ped_green", want.lamps[3], ped_green);
          check_field("ped_yellow", want.lamps[4], ped_yellow);
          check_field("ped_red", want.lamps[5], ped_red);
          check_field("phase_code", want.phase, phase_code);
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        accepted_n++;
        predict_lights(req_type, button_level);
      end
    end
  end

  // Test sequence.
  initial begin
    int n_items;
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a few ticks and a press that stays latched.
    push_beat(REQ_TICK, 1'b0);
    push_beat(REQ_PRESS, 1'b0);
    push_beat(REQ_TICK, 1'b1);
    push_beat(REQ_TICK, 1'b0);
    push_beat(REQ_PRESS, 1'b1);
    push_beat(REQ_TICK, 1'b0);
    drain();

    // Shortest lengths: long press, press during debounce, presses during a
    // pedestrian sequence, and the sequence from an interrupted green phase.
    program_regs(16'd2, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    push_beat(REQ_PRESS, 1'b0);
    push_beat(REQ_TICK, 1'b1);
    push_beat(REQ_TICK, 1'b1);
    push_beat(REQ_PRESS, 1'b0);
    push_beat(REQ_TICK, 1'b0);
    push_beat(REQ_PRESS, 1'b0);
    push_beat(REQ_TICK, 1'b1);
    push_beat(REQ_TICK, 1'b0);
    push_beat(REQ_PRESS, 1'b1);
    for (int i = 0; i < 6; i++) push_beat(REQ_TICK, 1'b0);
    push_beat(REQ_PRESS, 1'b0);
    for (int i = 0; i < 3; i++) push_beat(REQ_TICK, 1'b0);
    drain();

    // Random traffic under a series of settings.
    for (int s = 0; s < 8; s++) begin
      n_items = 120;
      case (s)
        1: begin
          program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
          write_reg(REG_UNUSED, 16'($urandom));
        end
        2: begin
          program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF);
          n_items = 30;
        end
        3: program_regs(16'($urandom_range(10, 30)), 16'($urandom_range(2, 9)),
                        16'($urandom_range(2, 6)), 16'($urandom_range(1, 5)),
                        16'($urandom_range(1, 4)), 16'($urandom_range(5, 20)),
                        16'($urandom_range(3, 10)));
        default: program_regs(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
                              16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
                              16'($urandom_range(1, 3)), 16'($urandom_range(1, 6)),
                              16'($urandom_range(1, 4)));
      endcase
      push_random(n_items);
      drain();
    end

    if (err_n == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ptl_pkg.sv
rtl/ptl_rem.sv
rtl/ptl_fsm.sv
rtl/pedestrian_traffic_light_fsm_top.sv
bench/tb_pedestrian_traffic_light_fsm_top.sv
